### sv/jac_pkg.sv
package jac_pkg;

  // Field widths
  localparam int AdcBits  = 12;
  localparam int CfgW     = 15;
  localparam int CfgIdxW  = 3;
  localparam int PosW     = 8;
  localparam int MagW     = PosW - 1;
  localparam int EvCount  = 5;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgXCenter  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgXNegSpan = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgXPosSpan = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgYCenter  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgYNegSpan = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgYPosSpan = 3'd5;

  // Register reset values
  localparam logic [CfgW-1:0] CenterReset = 15'd1800;
  localparam logic [CfgW-1:0] SpanReset   = 15'd500;

  // Conditioning constants
  localparam int LinNum    = 4095000;
  localparam int LinMax    = 32767;
  localparam int LinSatRaw = LinNum / (LinMax + 1);  // samples at or below saturate
  localparam int Scale     = 200;
  localparam int Lim       = 127;
  localparam int Trip      = 96;
  localparam int Rearm     = 32;

  // Event bits in the pending word
  localparam int EvLeft  = 0;
  localparam int EvRight = 1;
  localparam int EvUp    = 2;
  localparam int EvDown  = 3;
  localparam int EvPress = 4;

  // Shared divider sizing
  localparam int DivNW = 23;               // covers LinNum and 32767 * 200
  localparam int DivDW = CfgW;
  localparam int QuotW = 15;
  localparam int StepW = 4;
  localparam int DshW  = DivDW + QuotW - 1;
  localparam logic [StepW-1:0] LinSteps = 4'd15;
  localparam logic [StepW-1:0] SclSteps = 4'(MagW);

  // Queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  typedef struct packed {
    logic [CfgW-1:0] center;
    logic [CfgW-1:0] neg_span;
    logic [CfgW-1:0] pos_span;
  } axis_cfg_t;

  typedef struct packed {
    logic [AdcBits-1:0] raw_x;
    logic [AdcBits-1:0] raw_y;
    logic               zero_x;
    logic               zero_y;
    logic               press;
    logic               consume;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
    logic [StepW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

endpackage

### sv/jac_in_if.sv
interface jac_in_if;
  logic                        valid;
  logic                        ready;
  logic [jac_pkg::AdcBits-1:0] raw_x;
  logic [jac_pkg::AdcBits-1:0] raw_y;
  logic                        key_level;
  logic                        consume;

  modport source (output valid, raw_x, raw_y, key_level, consume, input ready);
  modport sink (input valid, raw_x, raw_y, key_level, consume, output ready);
endinterface

### sv/jac_out_if.sv
interface jac_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [jac_pkg::PosW-1:0] pos_x;
  logic signed [jac_pkg::PosW-1:0] pos_y;
  logic                            ev_left;
  logic                            ev_right;
  logic                            ev_up;
  logic                            ev_down;
  logic                            ev_press;

  modport source (output valid, pos_x, pos_y, ev_left, ev_right, ev_up, ev_down, ev_press,
                  input ready);
  modport sink (input valid, pos_x, pos_y, ev_left, ev_right, ev_up, ev_down, ev_press,
                output ready);
endinterface

### sv/jac_front.sv
module jac_front (
  input  logic            clk,
  input  logic            rst,
  jac_in_if.sink          sample,
  output logic            push_valid,
  input  logic            push_ready,
  output jac_pkg::item_t  push_item
);

  logic key_held;
  logic accept;

  assign accept       = sample.valid && push_ready;
  assign sample.ready = push_ready;
  assign push_valid   = sample.valid;

  // Key edge detect: press on the first low level after release
  always_ff @(posedge clk) begin
    if (rst) begin
      key_held <= 1'b0;
    end else if (accept) begin
      key_held <= !sample.key_level;
    end
  end

  // Classify the item for the back end
  always_comb begin
    push_item.raw_x   = sample.raw_x;
    push_item.raw_y   = sample.raw_y;
    push_item.zero_x  = (sample.raw_x == '0);
    push_item.zero_y  = (sample.raw_y == '0);
    push_item.press   = !sample.key_level && !key_held;
    push_item.consume = sample.consume;
  end

endmodule

### sv/jac_queue.sv
module jac_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  jac_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output jac_pkg::item_t  pop_item
);

  jac_pkg::item_t                entries [jac_pkg::QDepth];
  logic [jac_pkg::QPtrW-1:0]     wp;
  logic [jac_pkg::QPtrW-1:0]     rp;
  logic [jac_pkg::QPtrW:0]       count;
  logic                          push;
  logic                          pop;

  assign push_ready = (count != (jac_pkg::QPtrW + 1)'(jac_pkg::QDepth));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rp];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + (jac_pkg::QPtrW + 1)'(push) - (jac_pkg::QPtrW + 1)'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_item;
    end
  end

endmodule

### sv/jac_div.sv
module jac_div (
  input  logic               clk,
  input  logic               rst,
  input  jac_pkg::div_req_t  req,
  output jac_pkg::div_rsp_t  rsp
);

  logic [jac_pkg::DivNW-1:0] rem;
  logic [jac_pkg::DshW-1:0]  dsh;
  logic [jac_pkg::QuotW-1:0] quot;
  logic [jac_pkg::StepW-1:0] cnt;
  logic                      busy;
  logic                      done;
  logic                      fits;

  // Restoring step: quotient is known to fit in the requested number of bits
  assign fits = (jac_pkg::DshW'(rem) >= dsh);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == jac_pkg::StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.dividend;
      dsh  <= jac_pkg::DshW'(req.divisor) << (req.steps - 1'b1);
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - jac_pkg::DivNW'(dsh);
      end
      quot <= {quot[jac_pkg::QuotW-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

### sv/jac_back.sv
module jac_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  jac_pkg::item_t      pop_item,
  input  jac_pkg::axis_cfg_t  cfg_x,
  input  jac_pkg::axis_cfg_t  cfg_y,
  output jac_pkg::div_req_t   div_req,
  input  jac_pkg::div_rsp_t   div_rsp,
  jac_out_if.source           result
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LIN  = 4'd1;
  localparam logic [3:0] S_LINW = 4'd2;
  localparam logic [3:0] S_DIFF = 4'd3;
  localparam logic [3:0] S_SCL  = 4'd4;
  localparam logic [3:0] S_SCLW = 4'd5;
  localparam logic [3:0] S_HYST = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0]                       state;
  logic                             axis;
  jac_pkg::item_t                   cur;
  logic [jac_pkg::CfgW-1:0]         lin;
  logic                             neg;
  logic [jac_pkg::DivNW-1:0]        prod;
  logic [jac_pkg::MagW-1:0]         mag;
  logic signed [jac_pkg::PosW-1:0]  px;
  logic signed [jac_pkg::PosW-1:0]  py;
  logic                             x_tripped;
  logic                             y_tripped;
  logic [jac_pkg::EvCount-1:0]      pending;
  logic                             out_valid;

  jac_pkg::axis_cfg_t               cfg_a;
  logic [jac_pkg::AdcBits-1:0]      raw_a;
  logic                             zero_a;
  logic                             sat_lin;
  logic signed [jac_pkg::CfgW+1:0]  diff;
  logic                             diff_neg;
  logic [jac_pkg::CfgW-1:0]         dmag;
  logic [jac_pkg::CfgW-1:0]         span_raw;
  logic [jac_pkg::CfgW-1:0]         span;
  logic                             clamp_scl;
  logic signed [jac_pkg::PosW-1:0]  pval;
  logic                             trip_a;
  logic [2:0]                       ev_idx;
  logic                             out_free;

  // Per-axis selection
  always_comb begin
    cfg_a    = axis ? cfg_y : cfg_x;
    raw_a    = axis ? cur.raw_y : cur.raw_x;
    zero_a   = axis ? cur.zero_y : cur.zero_x;
    trip_a   = axis ? y_tripped : x_tripped;
    sat_lin  = (raw_a <= jac_pkg::AdcBits'(jac_pkg::LinSatRaw));
    diff     = $signed({2'b00, lin}) - $signed({2'b00, cfg_a.center});
    diff_neg = diff[jac_pkg::CfgW+1];
    dmag     = jac_pkg::CfgW'(diff_neg ? -diff : diff);
    span_raw = neg ? cfg_a.neg_span : cfg_a.pos_span;
    span     = (span_raw == '0) ? jac_pkg::CfgW'(1) : span_raw;
    clamp_scl = (prod >= jac_pkg::DivNW'({span, {jac_pkg::MagW{1'b0}}}));
    pval     = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    ev_idx   = {1'b0, axis, !neg};
    out_free = !out_valid || result.ready;
  end

  // Divider requests
  always_comb begin
    div_req.start    = ((state == S_LIN) && !zero_a && !sat_lin) ||
                       ((state == S_SCL) && !clamp_scl);
    div_req.dividend = (state == S_LIN) ? jac_pkg::DivNW'(jac_pkg::LinNum) : prod;
    div_req.divisor  = (state == S_LIN) ? jac_pkg::DivDW'(raw_a) : span;
    div_req.steps    = (state == S_LIN) ? jac_pkg::LinSteps : jac_pkg::SclSteps;
  end

  assign pop_ready = (state == S_IDLE);

  // Sequencer and event state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= 1'b0;
      x_tripped <= 1'b0;
      y_tripped <= 1'b0;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            pending[jac_pkg::EvPress] <= pending[jac_pkg::EvPress] | pop_item.press;
            axis  <= 1'b0;
            state <= S_LIN;
          end
        end
        S_LIN: begin
          if (zero_a) begin
            state <= S_HYST;
          end else if (sat_lin) begin
            state <= S_DIFF;
          end else begin
            state <= S_LINW;
          end
        end
        S_LINW: begin
          if (div_rsp.done) begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          state <= (dmag == '0) ? S_HYST : S_SCL;
        end
        S_SCL: begin
          state <= clamp_scl ? S_HYST : S_SCLW;
        end
        S_SCLW: begin
          if (div_rsp.done) begin
            state <= S_HYST;
          end
        end
        S_HYST: begin
          // trip above the high threshold, re-arm inside the low one
          if ((mag > jac_pkg::MagW'(jac_pkg::Trip)) && !trip_a) begin
            pending[ev_idx] <= 1'b1;
            if (axis) begin
              y_tripped <= 1'b1;
            end else begin
              x_tripped <= 1'b1;
            end
          end
          if (mag < jac_pkg::MagW'(jac_pkg::Rearm)) begin
            if (axis) begin
              y_tripped <= 1'b0;
            end else begin
              x_tripped <= 1'b0;
            end
          end
          if (axis) begin
            state <= S_OUT;
          end else begin
            axis  <= 1'b1;
            state <= S_LIN;
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (cur.consume) begin
              pending <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && pop_valid) begin
      cur <= pop_item;
    end
    if (state == S_LIN) begin
      lin <= jac_pkg::CfgW'(jac_pkg::LinMax);
      mag <= '0;
      neg <= 1'b0;
    end
    if ((state == S_LINW) && div_rsp.done) begin
      lin <= div_rsp.quot;
    end
    if (state == S_DIFF) begin
      neg  <= diff_neg;
      mag  <= '0;
      prod <= jac_pkg::DivNW'(dmag) * jac_pkg::DivNW'(jac_pkg::Scale);
    end
    if (state == S_SCL) begin
      mag <= jac_pkg::MagW'(jac_pkg::Lim);
    end
    if ((state == S_SCLW) && div_rsp.done) begin
      mag <= div_rsp.quot[jac_pkg::MagW-1:0];
    end
    if (state == S_HYST) begin
      if (axis) begin
        py <= pval;
      end else begin
        px <= pval;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      result.pos_x    <= px;
      result.pos_y    <= py;
      result.ev_left  <= pending[jac_pkg::EvLeft];
      result.ev_right <= pending[jac_pkg::EvRight];
      result.ev_up    <= pending[jac_pkg::EvUp];
      result.ev_down  <= pending[jac_pkg::EvDown];
      result.ev_press <= pending[jac_pkg::EvPress];
    end
  end

  assign result.valid = out_valid;

endmodule

### sv/joystick_axis_conditioner.sv
// The back end takes a new item only after the result of the last one is registered
// at the output; a two-entry queue buffers samples in front of it. A zero sample skips the divider.
// All division goes through the single shared divider, which runs up to two
// divisions per axis (15 bits to linearize, 7 bits to scale).
// Reset (rst, synchronous): clears events, latches and queue; config to defaults.
module joystick_axis_conditioner (
  input  logic                         clk,
  input  logic                         rst,
  jac_in_if.sink                       sample,
  jac_out_if.source                    result,
  input  logic                         cfg_we,
  input  logic [jac_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [jac_pkg::CfgW-1:0]     cfg_data
);

  jac_pkg::axis_cfg_t cfg_x;
  jac_pkg::axis_cfg_t cfg_y;
  logic               push_valid;
  logic               push_ready;
  jac_pkg::item_t     push_item;
  logic               pop_valid;
  logic               pop_ready;
  jac_pkg::item_t     pop_item;
  jac_pkg::div_req_t  div_req;
  jac_pkg::div_rsp_t  div_rsp;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_x.center   <= jac_pkg::CenterReset;
      cfg_x.neg_span <= jac_pkg::SpanReset;
      cfg_x.pos_span <= jac_pkg::SpanReset;
      cfg_y.center   <= jac_pkg::CenterReset;
      cfg_y.neg_span <= jac_pkg::SpanReset;
      cfg_y.pos_span <= jac_pkg::SpanReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jac_pkg::CfgXCenter:  cfg_x.center   <= cfg_data;
        jac_pkg::CfgXNegSpan: cfg_x.neg_span <= cfg_data;
        jac_pkg::CfgXPosSpan: cfg_x.pos_span <= cfg_data;
        jac_pkg::CfgYCenter:  cfg_y.center   <= cfg_data;
        jac_pkg::CfgYNegSpan: cfg_y.neg_span <= cfg_data;
        jac_pkg::CfgYPosSpan: cfg_y.pos_span <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  jac_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  jac_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  jac_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  jac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .cfg_x     (cfg_x),
    .cfg_y     (cfg_y),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .result    (result)
  );

endmodule
